// File: design/mhpq_pkg.sv
package mhpq_pkg;

  // Heap geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KID_W    = IDX_W + 1;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // One stored task: priority in the upper half, id in the lower half.
  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] task_id;
    logic [15:0] task_priority;
  } in_t;

  typedef struct packed {
    logic             removed_valid;
    logic [15:0]      removed_id;
    logic [15:0]      removed_priority;
    logic             top_valid;
    logic [15:0]      top_id;
    logic [15:0]      top_priority;
    logic [CNT_W-1:0] entry_count;
    logic             overflow;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic rd_last;
    logic ld_last;
    logic rd_parent;
    logic up_step;
    logic rd_kids;
    logic dn_step;
    logic place;
    logic fin;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_deq;
    logic full;
    logic empty;
    logic single;
    logic hole_root;
    logic kids_none;
    logic up_move;
    logic dn_move;
  } dp_stat_t;

endpackage

// File: design/max_heap_priority_queue_unit.sv
// Channel | Handshake                 | Payload
// input   | in_valid / in_stall       | in_data  (op, task_id, task_priority)
// output  | out_valid / out_stall     | out_data (removed, top, entry_count, overflow)
//
// One item at a time. An enqueue sifts the new task up from the end of the heap,
// with a parent read and a compare for each level that it rises; a dequeue reads
// the last entry, loads it as the task to place at the root and sifts it down,
// with a read of both children and a compare for each level that it sinks. A
// dropped enqueue, or a dequeue from a heap of at most one task, goes straight to
// the result. Reset clears the fill count, so the memory needs no clearing. The
// result register holds while out_stall is high, and the next input transfer is
// taken meanwhile; the following result waits.
module max_heap_priority_queue_unit import mhpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mhpq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: design/mhpq_datapath.sv
module mhpq_datapath import mhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  in_t      in_data,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  output out_t     out_data
);

  // Heap storage: one write port, two registered read ports.
  entry_t mem [CAPACITY];
  entry_t rdata_a;
  entry_t rdata_b;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] hole;
  entry_t           carry;
  entry_t           top;
  logic             rem_valid;
  entry_t           rem;
  logic             ovf;
  out_t             out_reg;

  logic [IDX_W-1:0] parent_idx;
  logic [KID_W-1:0] lc;
  logic [KID_W-1:0] rc;
  logic             lc_in;
  logic             rc_in;
  logic             lc_better;
  logic             rc_better;
  logic [15:0]      best_prio;
  entry_t           kid;
  logic [IDX_W-1:0] kid_idx;
  logic             up_move;
  logic             dn_move;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic             wr_en;
  entry_t           wr_data;
  entry_t           in_entry;

  // Index arithmetic around the hole that the moving task leaves.
  assign parent_idx = IDX_W'(hole - IDX_W'(1)) >> 1;
  assign lc         = {hole, 1'b1};
  assign rc         = KID_W'({hole, 1'b0} + KID_W'(2));
  assign lc_in      = lc < count;
  assign rc_in      = rc < count;

  // Sift-up: the parent moves down only if strictly lower.
  assign up_move = rdata_a.prio < carry.prio;

  // Sift-down: pick the strictly larger child, left child wins a tie.
  assign lc_better = rdata_a.prio > carry.prio;
  assign best_prio = lc_better ? rdata_a.prio : carry.prio;
  assign rc_better = rc_in && (rdata_b.prio > best_prio);
  assign dn_move   = lc_better || rc_better;
  assign kid       = rc_better ? rdata_b : rdata_a;
  assign kid_idx   = rc_better ? rc[IDX_W-1:0] : lc[IDX_W-1:0];

  assign in_entry = '{prio: in_data.task_priority, id: in_data.task_id};

  // Read address selection.
  always_comb begin
    rd_en     = cmd.rd_last || cmd.rd_parent || cmd.rd_kids;
    rd_addr_a = lc[IDX_W-1:0];
    rd_addr_b = rc[IDX_W-1:0];
    if (cmd.rd_last) begin
      rd_addr_a = count[IDX_W-1:0];
    end else if (cmd.rd_parent) begin
      rd_addr_a = parent_idx;
    end
  end

  // Write selection: a moving neighbor or the carried task lands in the hole.
  always_comb begin
    wr_en   = cmd.place || cmd.up_step || cmd.dn_step;
    wr_data = carry;
    if (cmd.up_step && up_move) begin
      wr_data = rdata_a;
    end else if (cmd.dn_step && dn_move) begin
      wr_data = kid;
    end
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[hole] <= wr_data;
    end
    if (rd_en) begin
      rdata_a <= mem[rd_addr_a];
      rdata_b <= mem[rd_addr_b];
    end
  end

  // Fill count and top-of-heap copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.start) begin
      if (in_data.op == OP_ENQ) begin
        if (count != CNT_W'(CAPACITY)) begin
          count <= count + CNT_W'(1);
        end
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && hole == '0) begin
      top <= wr_data;
    end
  end

  // Moving task, hole position and per-item result flags.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      if (in_data.op == OP_ENQ) begin
        ovf       <= (count == CNT_W'(CAPACITY));
        rem_valid <= 1'b0;
        rem       <= '0;
        carry     <= in_entry;
        hole      <= count[IDX_W-1:0];
      end else begin
        ovf       <= 1'b0;
        rem_valid <= (count != '0);
        rem       <= (count != '0) ? top : '0;
      end
    end else if (cmd.ld_last) begin
      carry <= rdata_a;
      hole  <= '0;
    end else if (cmd.up_step && up_move) begin
      hole <= parent_idx;
    end else if (cmd.dn_step && dn_move) begin
      hole <= kid_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_reg.removed_valid    <= rem_valid;
      out_reg.removed_id       <= rem.id;
      out_reg.removed_priority <= rem.prio;
      out_reg.top_valid        <= (count != '0);
      out_reg.top_id           <= (count != '0) ? top.id : 16'd0;
      out_reg.top_priority     <= (count != '0) ? top.prio : 16'd0;
      out_reg.entry_count      <= count;
      out_reg.overflow         <= ovf;
    end
  end

  assign out_data = out_reg;

  // Status toward the controller.
  assign stat.req_deq   = (in_data.op == OP_DEQ);
  assign stat.full      = (count == CNT_W'(CAPACITY));
  assign stat.empty     = (count == '0);
  assign stat.single    = (count == CNT_W'(1));
  assign stat.hole_root = (hole == '0);
  assign stat.kids_none = !lc_in;
  assign stat.up_move   = up_move;
  assign stat.dn_move   = dn_move;

endmodule

// File: design/mhpq_ctrl.sv
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST_RD,
    S_LAST_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Command decode and next-state logic.
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          if (stat.req_deq) begin
            state_next = (stat.empty || stat.single) ? S_FIN : S_LAST_RD;
          end else begin
            state_next = stat.full ? S_FIN : S_UP_RD;
          end
        end
      end
      S_LAST_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_LAST_LD;
      end
      S_LAST_LD: begin
        cmd.ld_last = 1'b1;
        state_next  = S_DN_RD;
      end
      S_UP_RD: begin
        if (stat.hole_root) begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd.up_step = 1'b1;
        state_next  = stat.up_move ? S_UP_RD : S_FIN;
      end
      S_DN_RD: begin
        if (stat.kids_none) begin
          cmd.place  = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd_kids = 1'b1;
          state_next  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.dn_step = 1'b1;
        state_next  = stat.dn_move ? S_DN_RD : S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
